// ----- src/window_average_to_mulaw_8k_macros.svh -----
// Assertion macros shared by the window averaging block.
`ifndef WINDOW_AVERAGE_TO_MULAW_8K_MACROS_SVH
`define WINDOW_AVERAGE_TO_MULAW_8K_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define WAVG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define WAVG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/wavgmu_pkg.sv -----
package wavgmu_pkg;

  localparam int          SAMPLE_W       = 16;
  localparam int          CODE_W         = 8;
  localparam int          CFG_RATE_W     = 18;
  localparam int          CFG_ADDR_W     = 3;
  localparam int          CFG_DATA_W     = 32;
  localparam int unsigned OUT_RATE       = 8000;
  localparam int unsigned MIN_RATE       = 1000;
  localparam int unsigned RESET_RATE     = 16000;
  localparam int          RESULT_CAP     = 8;
  localparam int          WAVG_MAX_WINDOW = 24;

  // Register index, taken from paddr above the byte offset
  localparam logic [CFG_ADDR_W-3:0] REG_INPUT_RATE = '0;

  localparam int unsigned MULAW_BIAS = 'h84;
  localparam int unsigned MULAW_CLIP = 32635;

  // Inverted G.711 mu-law code of a sign and magnitude (magnitude up to 32768)
  function automatic logic [CODE_W-1:0] mulaw_encode(input logic neg,
                                                     input logic [SAMPLE_W-1:0] mag);
    logic [14:0] biased;
    logic [2:0]  seg;
    logic [3:0]  mant;
    logic        sgn;
    sgn    = neg && (mag != '0);
    biased = (mag > SAMPLE_W'(MULAW_CLIP)) ? 15'(MULAW_CLIP) : mag[14:0];
    biased = biased + 15'(MULAW_BIAS);
    seg    = '0;
    for (int k = 1; k < 8; k++) begin
      if (biased[k+7]) seg = 3'(k);
    end
    mant = 4'(biased >> ({1'b0, seg} + 4'd3));
    return ~{sgn, seg, mant};
  endfunction

endpackage

// ----- src/window_average_to_mulaw_8k.sv -----
// Boxcar decimator to 8 kHz with a G.711 mu-law encoder.
// Input channel: in_sample (signed 16-bit PCM) and in_stream_end, taken on a
// valid/stall handshake. A request is taken only while the block is idle.
// Result channel: out_mulaw_byte and out_run_last (high on the final byte that
// a sample causes), valid/stall, from a single output register.
// Configuration: APB-style port, register input_rate at byte address 0; a
// write restarts the window state. Rates saturate to 1000 .. 8000*MAX_WINDOW.
// Sequence per request: at 8 kHz and above, ST_HI closes each window that
// ends before the sample, ST_HI_ADD accumulates the sample, ST_HI_EQ closes
// a window that ends on it and ST_DONE rebases the boundary; below 8 kHz,
// ST_LO emits the repeated bytes, then ST_DONE. An averaged byte goes
// through the restoring divider (ST_DIV), which retires one quotient bit a
// cycle, and then ST_OUT, before the sequencer returns to ST_HI, or to
// ST_DONE when the request's own sample closed the window. Below 8 kHz each
// byte goes through ST_OUT. While the receiver stalls, the pending byte
// waits in the output register and the sequencer holds until the register
// drains.
// Reset (rst_n low at a clock edge): rate 16000, window state restarted, no
// clearing pass; the block is ready in the first cycle after reset.
`include "window_average_to_mulaw_8k_macros.svh"

module window_average_to_mulaw_8k
  import wavgmu_pkg::*;
#(
  parameter int MAX_WINDOW = WAVG_MAX_WINDOW
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                  in_stream_end,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CODE_W-1:0]     out_mulaw_byte,
  output logic                  out_run_last,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int SUM_W  = $clog2(MAX_WINDOW * (1 << (SAMPLE_W - 1)) + 1) + 1;
  localparam int MAG_W  = SUM_W - 1;
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int RATE_W = $clog2(OUT_RATE * MAX_WINDOW + 1);
  localparam int BND_W  = RATE_W + 1;
  localparam int DIVC_W = $clog2(MAG_W + 1);
  localparam int N_W    = $clog2(RESULT_CAP + 1);
  localparam int unsigned MAX_RATE = OUT_RATE * MAX_WINDOW;

  localparam logic [BND_W-1:0] OUT_RATE_B   = BND_W'(OUT_RATE);
  localparam logic [N_W-1:0]   RESULT_CAP_N = N_W'(RESULT_CAP);

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;  // take a request
  localparam logic [2:0] ST_LO     = 3'd1;  // below 8 kHz: repeat samples
  localparam logic [2:0] ST_HI     = 3'd2;  // close windows ending before this sample
  localparam logic [2:0] ST_HI_ADD = 3'd3;  // accumulate the sample
  localparam logic [2:0] ST_HI_EQ  = 3'd4;  // close a window ending on this sample
  localparam logic [2:0] ST_DIV    = 3'd5;  // bit-serial divide of sum by count
  localparam logic [2:0] ST_OUT    = 3'd6;  // load the output register
  localparam logic [2:0] ST_DONE   = 3'd7;  // rebase the boundary, restart on stream end

  function automatic logic [RATE_W-1:0] clamp_rate(input logic [CFG_RATE_W-1:0] req);
    logic [31:0] wide;
    wide = 32'(req);
    if (wide < MIN_RATE) wide = MIN_RATE;
    else if (wide > MAX_RATE) wide = MAX_RATE;
    return RATE_W'(wide);
  endfunction

  // Control and window state
  logic [2:0]            state_r, state_nxt;
  logic [2:0]            ret_r, ret_nxt;
  logic [CFG_RATE_W-1:0] input_rate_r, input_rate_nxt;
  logic [RATE_W-1:0]     rate_use_r, rate_use_nxt;
  logic [BND_W-1:0]      d_r, d_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [N_W-1:0]        n_r, n_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DIVC_W-1:0]     div_cnt_r, div_cnt_nxt;

  // Payload
  logic [SAMPLE_W-1:0]   x_r, x_nxt;
  logic                  last_r, last_nxt;
  logic                  res_last_r, res_last_nxt;
  logic                  val_neg_r, val_neg_nxt;
  logic [SAMPLE_W-1:0]   val_mag_r, val_mag_nxt;
  logic [MAG_W-1:0]      div_q_r, div_q_nxt;
  logic [CNT_W-1:0]      div_rem_r, div_rem_nxt;
  logic [CNT_W-1:0]      div_den_r, div_den_nxt;
  logic                  div_neg_r, div_neg_nxt;
  logic [CODE_W-1:0]     out_code_r, out_code_nxt;
  logic                  out_last_r, out_last_nxt;

  // Datapath
  logic [SUM_W-1:0]      x_ext;
  logic [SAMPLE_W-1:0]   x_mag;
  logic [SUM_W-1:0]      sum_mag;
  logic [BND_W-1:0]      rate_b;
  logic [BND_W-1:0]      d_add;
  logic [N_W-1:0]        n_inc;
  logic [CNT_W:0]        rem_sh;
  logic [CNT_W:0]        rem_sub;
  logic                  rem_ge;
  logic [MAG_W-1:0]      q_step;
  logic                  slot_free;
  logic                  cfg_sel_rate;
  logic                  cfg_wr;
  logic [RATE_W-1:0]     rate_wr;

  assign x_ext   = {{(SUM_W - SAMPLE_W){x_r[SAMPLE_W-1]}}, x_r};
  assign x_mag   = x_r[SAMPLE_W-1] ? (~x_r + SAMPLE_W'(1)) : x_r;
  assign sum_mag = sum_r[SUM_W-1] ? (~sum_r + SUM_W'(1)) : sum_r;
  assign rate_b  = {1'b0, rate_use_r};
  assign d_add   = d_r + rate_b;
  assign n_inc   = n_r + N_W'(1);

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh  = {div_rem_r, div_q_r[MAG_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, div_den_r};
  assign rem_sub = rem_sh - {1'b0, div_den_r};
  assign q_step  = {div_q_r[MAG_W-2:0], rem_ge};

  assign slot_free    = !out_valid_r || !out_stall;
  assign cfg_sel_rate = cfg_paddr[CFG_ADDR_W-1:2] == REG_INPUT_RATE;
  assign cfg_wr       = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_rate;
  assign rate_wr      = clamp_rate(cfg_pwdata[CFG_RATE_W-1:0]);

  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    input_rate_nxt = input_rate_r;
    rate_use_nxt   = rate_use_r;
    d_nxt          = d_r;
    sum_nxt        = sum_r;
    count_nxt      = count_r;
    n_nxt          = n_r;
    out_valid_nxt  = out_valid_r;
    div_cnt_nxt    = div_cnt_r;
    x_nxt          = x_r;
    last_nxt       = last_r;
    res_last_nxt   = res_last_r;
    val_neg_nxt    = val_neg_r;
    val_mag_nxt    = val_mag_r;
    div_q_nxt      = div_q_r;
    div_rem_nxt    = div_rem_r;
    div_den_nxt    = div_den_r;
    div_neg_nxt    = div_neg_r;
    out_code_nxt   = out_code_r;
    out_last_nxt   = out_last_r;

    // Drop the byte once the receiver takes it
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          x_nxt     = in_sample;
          last_nxt  = in_stream_end;
          n_nxt     = '0;
          state_nxt = (rate_use_r < RATE_W'(OUT_RATE)) ? ST_LO : ST_HI;
        end
      end
      ST_LO: begin
        if (d_r <= OUT_RATE_B && n_r < RESULT_CAP_N) begin
          // Boundary before this sample: repeat the previous one
          if (d_r < rate_b) begin
            val_neg_nxt = sum_r[SUM_W-1];
            val_mag_nxt = sum_mag[SAMPLE_W-1:0];
          end else begin
            val_neg_nxt = x_r[SAMPLE_W-1];
            val_mag_nxt = x_mag;
          end
          res_last_nxt = !(d_add <= OUT_RATE_B && n_inc < RESULT_CAP_N);
          d_nxt        = d_add;
          n_nxt        = n_inc;
          ret_nxt      = ST_LO;
          state_nxt    = ST_OUT;
        end else begin
          sum_nxt   = x_ext;
          count_nxt = CNT_W'(1);
          state_nxt = ST_DONE;
        end
      end
      ST_HI: begin
        if (d_r < OUT_RATE_B) begin
          div_q_nxt    = sum_mag[MAG_W-1:0];
          div_rem_nxt  = '0;
          div_den_nxt  = count_r;
          div_neg_nxt  = sum_r[SUM_W-1];
          div_cnt_nxt  = DIVC_W'(MAG_W);
          sum_nxt      = '0;
          count_nxt    = '0;
          res_last_nxt = !(d_add <= OUT_RATE_B);
          d_nxt        = d_add;
          ret_nxt      = ST_HI;
          state_nxt    = ST_DIV;
        end else begin
          state_nxt = ST_HI_ADD;
        end
      end
      ST_HI_ADD: begin
        sum_nxt   = sum_r + x_ext;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = ST_HI_EQ;
      end
      ST_HI_EQ: begin
        if (d_r == OUT_RATE_B) begin
          div_q_nxt    = sum_mag[MAG_W-1:0];
          div_rem_nxt  = '0;
          div_den_nxt  = count_r;
          div_neg_nxt  = sum_r[SUM_W-1];
          div_cnt_nxt  = DIVC_W'(MAG_W);
          sum_nxt      = '0;
          count_nxt    = '0;
          res_last_nxt = 1'b1;
          d_nxt        = d_add;
          ret_nxt      = ST_DONE;
          state_nxt    = ST_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        div_q_nxt   = q_step;
        div_rem_nxt = rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        div_cnt_nxt = div_cnt_r - DIVC_W'(1);
        if (div_cnt_r == DIVC_W'(1)) begin
          // An empty window averages to zero
          val_neg_nxt = div_neg_r;
          val_mag_nxt = (div_den_r == '0) ? '0 : q_step[SAMPLE_W-1:0];
          state_nxt   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = mulaw_encode(val_neg_r, val_mag_r);
          out_last_nxt  = res_last_r;
          state_nxt     = ret_r;
        end
      end
      ST_DONE: begin
        d_nxt = (d_r > OUT_RATE_B) ? (d_r - OUT_RATE_B) : '0;
        if (last_r) begin
          d_nxt     = rate_b;
          sum_nxt   = '0;
          count_nxt = '0;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A rate write restarts the stream
    if (cfg_wr) begin
      input_rate_nxt = cfg_pwdata[CFG_RATE_W-1:0];
      rate_use_nxt   = rate_wr;
      d_nxt          = {1'b0, rate_wr};
      sum_nxt        = '0;
      count_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ret_r        <= ST_IDLE;
      input_rate_r <= CFG_RATE_W'(RESET_RATE);
      rate_use_r   <= clamp_rate(CFG_RATE_W'(RESET_RATE));
      d_r          <= {1'b0, clamp_rate(CFG_RATE_W'(RESET_RATE))};
      sum_r        <= '0;
      count_r      <= '0;
      n_r          <= '0;
      out_valid_r  <= 1'b0;
      div_cnt_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      ret_r        <= ret_nxt;
      input_rate_r <= input_rate_nxt;
      rate_use_r   <= rate_use_nxt;
      d_r          <= d_nxt;
      sum_r        <= sum_nxt;
      count_r      <= count_nxt;
      n_r          <= n_nxt;
      out_valid_r  <= out_valid_nxt;
      div_cnt_r    <= div_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    last_r     <= last_nxt;
    res_last_r <= res_last_nxt;
    val_neg_r  <= val_neg_nxt;
    val_mag_r  <= val_mag_nxt;
    div_q_r    <= div_q_nxt;
    div_rem_r  <= div_rem_nxt;
    div_den_r  <= div_den_nxt;
    div_neg_r  <= div_neg_nxt;
    out_code_r <= out_code_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall       = state_r != ST_IDLE;
  assign out_valid      = out_valid_r;
  assign out_mulaw_byte = out_code_r;
  assign out_run_last   = out_last_r;
  assign cfg_pready     = 1'b1;
  assign cfg_prdata     = cfg_sel_rate ? CFG_DATA_W'(input_rate_r) : '0;

  // A taken request makes the sequencer busy in the next cycle
  `WAVG_ASSERT_NEXT(a_busy_after_request, clk, rst_n, in_valid && !in_stall, in_stall,
    "request taken but sequencer did not go busy")

  // Between requests the next boundary lies within one input period
  `WAVG_ASSERT_NOW(a_boundary_range, clk, rst_n, state_r == ST_IDLE,
    d_r != '0 && d_r <= rate_b, "boundary distance out of range while idle")

  // A partial window never holds more samples than the widest window
  `WAVG_ASSERT_NOW(a_count_bound, clk, rst_n, state_r == ST_IDLE,
    count_r <= CNT_W'(MAX_WINDOW), "window count exceeds MAX_WINDOW")

endmodule

// ----- bench/window_average_to_mulaw_8k_test.sv -----
`timescale 1ns / 1ps

module window_average_to_mulaw_8k_test;
  import wavgmu_pkg::*;

  // Allow this many cycles with no request, result or register access.
  localparam int QUIET_LIMIT   = 4000;
  // Cycles to let the block finish after the last expected byte.
  localparam int SETTLE_CYCLES = 64;
  // Segment threshold of the lowest mu-law segment.
  localparam int unsigned SEG_BASE = 'h100;
  // Plan entries with special pacing.
  localparam int STEADY_PHASE   = 7;
  localparam int PRESSURE_PHASE = 8;
  localparam int PLAN_LEN       = 14;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } mulaw_code_t;

  // Tracks the window state and queues the mu-law bytes that each request causes.
  class mulaw_window_tracker;
    logic [CFG_RATE_W-1:0] rate_reg;
    int unsigned           whole_left;
    int unsigned           part_left;
    int                    run_sum;
    int unsigned           run_count;
    logic [CODE_W-1:0]     fresh[$];
    mulaw_code_t           due_codes[$];
    int                    failures;

    function new();
      rate_reg = CFG_RATE_W'(RESET_RATE);
      failures = 0;
      restart_stream();
    endfunction

    function int unsigned rate_used();
      if (rate_reg < MIN_RATE) return MIN_RATE;
      if (rate_reg > OUT_RATE * WAVG_MAX_WINDOW) return OUT_RATE * WAVG_MAX_WINDOW;
      return rate_reg;
    endfunction

    function void restart_stream();
      whole_left = rate_used() / OUT_RATE;
      part_left  = rate_used() % OUT_RATE;
      run_sum    = 0;
      run_count  = 0;
    endfunction

    function void set_rate(logic [CFG_DATA_W-1:0] value);
      rate_reg = value[CFG_RATE_W-1:0];
      restart_stream();
    endfunction

    function logic [CODE_W-1:0] mulaw_code(int v);
      int unsigned mag;
      int unsigned seg;
      logic [3:0]  mant;
      logic        sgn;
      sgn = (v < 0);
      if (v < -32767) mag = 32767;
      else if (v < 0) mag = -v;
      else mag = v;
      if (mag > MULAW_CLIP) mag = MULAW_CLIP;
      mag = mag + MULAW_BIAS;
      seg = 7;
      while (seg > 0 && mag < (SEG_BASE << (seg - 1))) seg--;
      mant = 4'(mag >> (seg + 3));
      return ~{sgn, 3'(seg), mant};
    endfunction

    // Truncating mean of the window, then clear the window.
    function void close_window();
      int mean;
      mean = (run_count == 0) ? 0 : run_sum / int'(run_count);
      if (fresh.size() < RESULT_CAP) fresh.push_back(mulaw_code(mean));
      run_sum   = 0;
      run_count = 0;
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] s, logic stream_end);
      int unsigned r;
      int unsigned d;
      int          x;
      x = s;
      r = rate_used();
      d = whole_left * OUT_RATE + part_left;
      fresh.delete();
      if (r < OUT_RATE) begin
        // Slow input: each window is one sample, repeated as needed.
        while (d <= OUT_RATE && fresh.size() < RESULT_CAP) begin
          fresh.push_back(mulaw_code((d < r) ? run_sum : x));
          d += r;
        end
        run_sum   = x;
        run_count = 1;
      end else begin
        while (d < OUT_RATE) begin
          close_window();
          d += r;
        end
        run_sum += x;
        run_count++;
        if (d == OUT_RATE) begin
          close_window();
          d += r;
        end
      end
      d = (d > OUT_RATE) ? d - OUT_RATE : 0;
      whole_left = d / OUT_RATE;
      part_left  = d % OUT_RATE;
      foreach (fresh[k]) due_codes.push_back('{fresh[k], k == fresh.size() - 1});
      if (stream_end) restart_stream();
    endfunction

    function void check_byte(logic [CODE_W-1:0] code, logic last);
      mulaw_code_t want;
      if (due_codes.size() == 0) begin
        $error("out_mulaw_byte: none expected, got %02h", code);
        failures++;
        return;
      end
      want = due_codes.pop_front();
      if (code !== want.code) begin
        $error("out_mulaw_byte: expected %02h, got %02h", want.code, code);
        failures++;
      end
      if (last !== want.last) begin
        $error("out_run_last: expected %0b, got %0b", want.last, last);
        failures++;
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [SAMPLE_W-1:0]   in_sample = '0;
  logic                         in_stream_end = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [CODE_W-1:0]            out_mulaw_byte;
  logic                         out_run_last;
  logic                         cfg_psel = 1'b0;
  logic                         cfg_penable = 1'b0;
  logic                         cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]        cfg_paddr = '0;
  logic [CFG_DATA_W-1:0]        cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0]        cfg_prdata;
  logic                         cfg_pready;

  // High while neither side may idle.
  logic                         steady = 1'b0;
  int                           quiet_cycles = 0;
  mulaw_window_tracker          tracker = new();

  // Rates in order: below range, the lower limit, around 8 kHz, common rates,
  // a write with junk above the register, 96 kHz, the upper limit, beyond the top, back to reset rate.
  logic [CFG_DATA_W-1:0] rate_plan [0:PLAN_LEN-1] = '{
    32'd0, 32'd1000, 32'd7999, 32'd8000, 32'd8001, 32'd11025, 32'd22050,
    32'd44100, 32'hABC4_BB80, 32'd96000, 32'd192000, 32'd192001, 32'd262143,
    32'd16000
  };

  window_average_to_mulaw_8k i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .in_stream_end  (in_stream_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_mulaw_byte (out_mulaw_byte),
    .out_run_last   (out_run_last),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Stall the result side at random, about 22 percent of the time, except in the steady stretch.
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 22);
  end

  // Check every byte taken from the block against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      tracker.check_byte(out_mulaw_byte, out_run_last);
    end
  end

  // Abort if nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || cfg_psel || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("window_average_to_mulaw_8k: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one sample, with random gaps before it, and hold it until taken.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic stream_end);
    while (!steady && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_sample     <= s;
    in_stream_end <= stream_end;
    @(posedge clk);
    while (!(in_valid === 1'b1 && in_stall === 1'b0)) @(posedge clk);
    tracker.note_sample(s, stream_end);
  endtask

  // Drop valid and wait until every expected byte has come out.
  task automatic wait_for_codes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.due_codes.size() != 0) @(posedge clk);
  endtask

  // Write the rate register: setup cycle, then access cycle.
  task automatic write_rate(input logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_INPUT_RATE, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    tracker.set_rate(value);
  endtask

  // Mix of extremes, values around the clip level, small values and full noise.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int sel;
    int sgn;
    sel = $urandom_range(0, 9);
    sgn = $urandom_range(0, 1) ? 1 : -1;
    case (sel)
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
      3: return SAMPLE_W'(sgn * (32633 + int'($urandom_range(0, 4))));
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  initial begin
    int budget;
    int sent;
    int run;
    logic stop;

    // Hold reset, then release it once.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pairs at the reset rate (two samples to a window): full-scale
    // clip, the most negative sample, mean truncation toward zero, the clip
    // edge, and a stream end that drops a half-filled window.
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(-16'sd32767, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd2, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd32635, 1'b0);
    send_sample(16'sd32635, 1'b0);
    send_sample(16'sd32636, 1'b0);
    send_sample(16'sd32636, 1'b0);
    send_sample(-16'sd3, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd123, 1'b1);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd100, 1'b1);
    // Leave a window half full so that the first write also restarts mid-window.
    send_sample(16'sd77, 1'b0);

    // Random streams at each rate of the plan.
    for (int p = 0; p < PLAN_LEN; p++) begin
      wait_for_codes();
      repeat (SETTLE_CYCLES) @(posedge clk);
      write_rate(rate_plan[p]);
      steady <= (p == STEADY_PHASE);
      budget = (rate_plan[p][CFG_RATE_W-1:0] >= 96000) ? 28 : 10;
      sent = 0;
      while (sent < budget) begin
        run = $urandom_range(1, 40);
        for (int k = 0; k < run && sent < budget; k++) begin
          // Mostly end streams on their last sample, now and then end one early.
          stop = ((k == run - 1) && $urandom_range(0, 3) != 0) || ($urandom_range(0, 29) == 0);
          send_sample(pick_sample(), stop);
          sent++;
          // Hold the sender once until the block has drained.
          if (p == PRESSURE_PHASE && sent == 5) wait_for_codes();
        end
      end
    end

    // Drain, give the block time to show any stray byte, then report.
    wait_for_codes();
    steady <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.due_codes.size() != 0) begin
      $error("out_mulaw_byte: %0d expected bytes never came", tracker.due_codes.size());
      tracker.failures++;
    end
    if (tracker.failures == 0) begin
      $display("window_average_to_mulaw_8k: match");
    end else begin
      $display("window_average_to_mulaw_8k: mismatch");
    end
    $finish;
  end

endmodule
